// ===== hw/rtl/xmcr_pkg.sv =====
// xmcr_pkg: shared constants and types of the xmodem checksum receiver
// protocol bytes, action and verdict codes, register map, config and result structs
// depends on nothing
`default_nettype none

package xmcr_pkg;

  // block geometry
  localparam int BLOCK_BYTES_DEF = 128;
  localparam int INDEX_W         = 7;

  // protocol control bytes
  localparam logic [7:0] SOH = 8'h01;
  localparam logic [7:0] EOT = 8'h04;
  localparam logic [7:0] ACK = 8'h06;
  localparam logic [7:0] NAK = 8'h15;

  // input actions
  localparam int ACTION_W = 2;
  localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd2;

  // verdict codes
  localparam int VERDICT_W = 3;
  localparam logic [VERDICT_W-1:0] VERDICT_NONE      = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED  = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_ERROR     = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_DONE      = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_ABORTED   = 3'd5;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_SHORT_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_LONG_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_ERROR_LIMIT   = 2'd2;

  localparam logic [15:0] SHORT_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] LONG_TIMEOUT_RST  = 16'd10000;
  localparam logic [7:0]  ERROR_LIMIT_RST   = 8'd10;

  typedef struct packed {
    logic [15:0] short_timeout_ticks;
    logic [15:0] long_timeout_ticks;
    logic [7:0]  error_limit;
  } cfg_t;

  typedef struct packed {
    logic                 data_valid;
    logic [7:0]           data_byte;
    logic [INDEX_W-1:0]   byte_index;
    logic                 reply_valid;
    logic [7:0]           reply_byte;
    logic [VERDICT_W-1:0] verdict;
    logic [7:0]           block_number;
    logic [7:0]           retry_errors;
    logic [15:0]          total_errors;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/xmcr_if.sv =====
// xmcr_in_if and xmcr_out_if: valid/ready channels of the receiver core
// widths come from xmcr_pkg
`default_nettype none

interface xmcr_in_if;
  logic                          valid;
  logic                          ready;
  logic [xmcr_pkg::ACTION_W-1:0] action;
  logic [7:0]                    rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface xmcr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           data_valid;
  logic [7:0]                     data_byte;
  logic [xmcr_pkg::INDEX_W-1:0]   byte_index;
  logic                           reply_valid;
  logic [7:0]                     reply_byte;
  logic [xmcr_pkg::VERDICT_W-1:0] verdict;
  logic [7:0]                     block_number;
  logic [7:0]                     retry_errors;
  logic [15:0]                    total_errors;

  modport source (output valid, data_valid, data_byte, byte_index, reply_valid, reply_byte,
                  verdict, block_number, retry_errors, total_errors, input ready);
  modport sink   (input valid, data_valid, data_byte, byte_index, reply_valid, reply_byte,
                  verdict, block_number, retry_errors, total_errors, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/xmcr_cfg_regs.sv =====
// xmcr_cfg_regs: apb-style configuration registers (timeouts and error limit)
// depends on xmcr_pkg
`default_nettype none

module xmcr_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [xmcr_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [xmcr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [xmcr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output xmcr_pkg::cfg_t                       cfg_o
);

  xmcr_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_timeout_ticks <= xmcr_pkg::SHORT_TIMEOUT_RST;
      cfg_q.long_timeout_ticks  <= xmcr_pkg::LONG_TIMEOUT_RST;
      cfg_q.error_limit         <= xmcr_pkg::ERROR_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        xmcr_pkg::REG_SHORT_TIMEOUT: cfg_q.short_timeout_ticks <= pwdata[15:0];
        xmcr_pkg::REG_LONG_TIMEOUT:  cfg_q.long_timeout_ticks  <= pwdata[15:0];
        xmcr_pkg::REG_ERROR_LIMIT:   cfg_q.error_limit         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      xmcr_pkg::REG_SHORT_TIMEOUT: prdata = {16'd0, cfg_q.short_timeout_ticks};
      xmcr_pkg::REG_LONG_TIMEOUT:  prdata = {16'd0, cfg_q.long_timeout_ticks};
      xmcr_pkg::REG_ERROR_LIMIT:   prdata = {24'd0, cfg_q.error_limit};
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/xmcr_engine.sv =====
// xmcr_engine: input register plus the protocol state machine of the receiver
// depends on xmcr_pkg and xmcr_in_if
`default_nettype none

module xmcr_engine #(
  parameter int BLOCK_BYTES = xmcr_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  xmcr_in_if.sink             in_i,
  input  wire xmcr_pkg::cfg_t cfg_i,
  input  wire logic           take_i,   // result register can take a result
  output logic                push_o,
  output xmcr_pkg::res_t      res_o
);

  localparam int CNT_W = ($clog2(BLOCK_BYTES) > xmcr_pkg::INDEX_W) ?
                         $clog2(BLOCK_BYTES) : xmcr_pkg::INDEX_W;

  typedef enum logic [2:0] {
    PH_STOPPED, PH_HUNT, PH_NUM, PH_COMP, PH_DATA, PH_SUM, PH_PURGE
  } phase_e;

  // input register
  logic                          in_valid_q;
  logic [xmcr_pkg::ACTION_W-1:0] action_q;
  logic [7:0]                    byte_q;
  logic                          fire;

  // protocol state
  phase_e             phase_q, phase_d;
  logic [7:0]         last_q, last_d;
  logic [7:0]         hdr_q, hdr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [7:0]         sum_q, sum_d;
  logic [7:0]         run_q, run_d;
  logic [15:0]        tot_q, tot_d;
  logic [15:0]        sil_q, sil_d;
  logic               dup_q, dup_d;

  logic [8:0]         comp_sum;
  logic [7:0]         run_inc;
  logic [15:0]        tot_inc;
  logic [15:0]        sil_inc;
  logic [15:0]        lim_short;
  logic [15:0]        lim_long;
  logic               to_short;
  logic               to_long;
  xmcr_pkg::res_t     res;

  assign fire       = in_valid_q && take_i;
  assign in_i.ready = !in_valid_q || take_i;

  assign comp_sum  = {1'b0, hdr_q} + {1'b0, byte_q};
  assign run_inc   = (run_q == 8'hFF) ? run_q : run_q + 8'd1;
  assign tot_inc   = (last_q != 8'd0 && tot_q != 16'hFFFF) ? tot_q + 16'd1 : tot_q;
  assign sil_inc   = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;
  assign lim_short = (cfg_i.short_timeout_ticks == 16'd0) ? 16'd1 : cfg_i.short_timeout_ticks;
  assign lim_long  = (cfg_i.long_timeout_ticks == 16'd0) ? 16'd1 : cfg_i.long_timeout_ticks;
  assign to_short  = sil_inc >= lim_short;
  assign to_long   = sil_inc >= lim_long;

  always_comb begin
    phase_d = phase_q;
    last_d  = last_q;
    hdr_d   = hdr_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    run_d   = run_q;
    tot_d   = tot_q;
    sil_d   = sil_q;
    dup_d   = dup_q;
    res     = '0;

    if (action_q == xmcr_pkg::ACT_START) begin
      phase_d = PH_HUNT;
      last_d  = '0;
      hdr_d   = '0;
      cnt_d   = '0;
      sum_d   = '0;
      run_d   = '0;
      tot_d   = '0;
      sil_d   = '0;
      dup_d   = 1'b0;
    end else if (phase_q != PH_STOPPED && action_q == xmcr_pkg::ACT_BYTE) begin
      sil_d = '0;
      case (phase_q)
        PH_HUNT: begin
          if (byte_q == xmcr_pkg::SOH) begin
            phase_d = PH_NUM;
          end else if (byte_q == xmcr_pkg::EOT) begin
            res.reply_valid = 1'b1;
            res.reply_byte  = xmcr_pkg::ACK;
            res.verdict     = xmcr_pkg::VERDICT_DONE;
            phase_d         = PH_STOPPED;
          end
        end
        PH_NUM: begin
          hdr_d   = byte_q;
          phase_d = PH_COMP;
        end
        PH_COMP: begin
          if (comp_sum != 9'd255) begin
            run_d   = run_inc;
            tot_d   = tot_inc;
            dup_d   = 1'b0;
            phase_d = PH_PURGE;
          end else if (hdr_q == last_q + 8'd1) begin
            cnt_d   = '0;
            sum_d   = '0;
            phase_d = PH_DATA;
          end else if (hdr_q == last_q) begin
            dup_d   = 1'b1;
            phase_d = PH_PURGE;
          end else begin
            run_d   = run_inc;
            tot_d   = tot_inc;
            dup_d   = 1'b0;
            phase_d = PH_PURGE;
          end
        end
        PH_DATA: begin
          res.data_valid = 1'b1;
          res.data_byte  = byte_q;
          res.byte_index = cnt_q[xmcr_pkg::INDEX_W-1:0];
          sum_d          = sum_q + byte_q;
          cnt_d          = cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(BLOCK_BYTES - 1)) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          if (byte_q == sum_q) begin
            run_d           = '0;
            last_d          = hdr_q;
            res.reply_valid = 1'b1;
            res.reply_byte  = xmcr_pkg::ACK;
            res.verdict     = xmcr_pkg::VERDICT_ACCEPTED;
            phase_d         = PH_HUNT;
          end else begin
            run_d   = run_inc;
            tot_d   = tot_inc;
            dup_d   = 1'b0;
            phase_d = PH_PURGE;
          end
        end
        default: ;  // purge drops the byte
      endcase
    end else if (phase_q != PH_STOPPED && action_q == xmcr_pkg::ACT_TICK) begin
      sil_d = sil_inc;
      case (phase_q)
        PH_HUNT: begin
          if (to_long) begin
            run_d   = run_inc;
            tot_d   = tot_inc;
            dup_d   = 1'b0;
            sil_d   = '0;
            phase_d = PH_PURGE;
          end
        end
        PH_PURGE: begin
          if (to_short) begin
            sil_d           = '0;
            dup_d           = 1'b0;
            res.reply_valid = 1'b1;
            if (dup_q) begin
              res.reply_byte = xmcr_pkg::ACK;
              res.verdict    = xmcr_pkg::VERDICT_DUPLICATE;
              phase_d        = PH_HUNT;
            end else if (run_q >= cfg_i.error_limit) begin
              // error already counted on entry to purge
              res.reply_byte = xmcr_pkg::NAK;
              res.verdict    = xmcr_pkg::VERDICT_ABORTED;
              phase_d        = PH_STOPPED;
            end else begin
              res.reply_byte = xmcr_pkg::NAK;
              res.verdict    = xmcr_pkg::VERDICT_ERROR;
              phase_d        = PH_HUNT;
            end
          end
        end
        default: begin
          // silence inside a packet
          if (to_short) begin
            sil_d           = '0;
            run_d           = run_inc;
            tot_d           = tot_inc;
            res.reply_valid = 1'b1;
            res.reply_byte  = xmcr_pkg::NAK;
            if (run_inc >= cfg_i.error_limit) begin
              res.verdict = xmcr_pkg::VERDICT_ABORTED;
              phase_d     = PH_STOPPED;
            end else begin
              res.verdict = xmcr_pkg::VERDICT_ERROR;
              phase_d     = PH_HUNT;
            end
          end
        end
      endcase
    end

    res.block_number = last_d;
    res.retry_errors = run_d;
    res.total_errors = tot_d;
  end

  assign push_o = fire && (res.data_valid || res.reply_valid);
  assign res_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PH_STOPPED;
      last_q     <= '0;
      hdr_q      <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
      run_q      <= '0;
      tot_q      <= '0;
      sil_q      <= '0;
      dup_q      <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (take_i) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        phase_q <= phase_d;
        last_q  <= last_d;
        hdr_q   <= hdr_d;
        cnt_q   <= cnt_d;
        sum_q   <= sum_d;
        run_q   <= run_d;
        tot_q   <= tot_d;
        sil_q   <= sil_d;
        dup_q   <= dup_d;
      end
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      action_q <= in_i.action;
      byte_q   <= in_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/xmcr_out_reg.sv =====
// xmcr_out_reg: result register that drives the output channel
// depends on xmcr_pkg and xmcr_out_if
`default_nettype none

module xmcr_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire xmcr_pkg::res_t res_i,
  output logic                take_o,
  xmcr_out_if.source          out_o
);

  logic           valid_q;
  xmcr_pkg::res_t res_q;

  assign take_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.data_valid   = res_q.data_valid;
  assign out_o.data_byte    = res_q.data_byte;
  assign out_o.byte_index   = res_q.byte_index;
  assign out_o.reply_valid  = res_q.reply_valid;
  assign out_o.reply_byte   = res_q.reply_byte;
  assign out_o.verdict      = res_q.verdict;
  assign out_o.block_number = res_q.block_number;
  assign out_o.retry_errors = res_q.retry_errors;
  assign out_o.total_errors = res_q.total_errors;

endmodule

`default_nettype wire

// ===== hw/rtl/xmodem_checksum_receiver_core.sv =====
// xmodem_checksum_receiver_core: top level of the checksum xmodem receiver
// depends on xmcr_pkg, xmcr_if, xmcr_cfg_regs, xmcr_engine, xmcr_out_reg
//
// usage:
//   in_i carries one transaction per received serial byte (action 0), per timer
//   tick (action 1) or per start command (action 2). out_o carries a result
//   transaction whenever a tentative data byte, a reply byte or a verdict exists;
//   ticks without a timeout and dropped bytes give no result.
//   the apb port sets the short timeout, long timeout and error limit; write it
//   only while the block is idle. pready is always high.
// throughput and data path:
//   one transaction per cycle on in_i while out_o is not stalled. an accepted
//   transaction passes the input register and the protocol state machine; its
//   result is held in the result register that drives out_o. the state
//   update is the loop that sets the rate.
// reset:
//   the receiver is stopped until a start command; registers take their
//   defaults (1000, 10000, 10).
// stall:
//   while out_o is stalled the result is held and at most one more
//   transaction is taken into the input register, then in_i.ready drops.
`default_nettype none

module xmodem_checksum_receiver_core #(
  parameter int BLOCK_BYTES = xmcr_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  xmcr_in_if.sink                              in_i,
  xmcr_out_if.source                           out_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [xmcr_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [xmcr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [xmcr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  xmcr_pkg::cfg_t cfg;
  xmcr_pkg::res_t res;
  logic           push;
  logic           take;

  xmcr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  xmcr_engine #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg),
    .take_i (take),
    .push_o (push),
    .res_o  (res)
  );

  xmcr_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (res),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/xmcr_checker.sv =====
// xmcr_checker: port-level assertions on the result channel, bound to the top level
// depends on xmcr_pkg and xmodem_checksum_receiver_core
`default_nettype none

module xmcr_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           data_valid,
  input wire logic [7:0]                     data_byte,
  input wire logic [xmcr_pkg::INDEX_W-1:0]   byte_index,
  input wire logic                           reply_valid,
  input wire logic [7:0]                     reply_byte,
  input wire logic [xmcr_pkg::VERDICT_W-1:0] verdict
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable({data_valid, data_byte, byte_index,
                                                      reply_valid, reply_byte, verdict}))
    else $error("result changed while stalled");

  // a data byte and a reply never share one transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(data_valid && reply_valid))
    else $error("data byte and reply in one result");

  // every reply carries a verdict and every verdict a reply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (reply_valid == (verdict != xmcr_pkg::VERDICT_NONE)))
    else $error("reply and verdict disagree");

  // reply byte is ack or nak, and ack exactly for accepted, duplicate and done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && reply_valid |->
      ((reply_byte == xmcr_pkg::ACK) ==
       (verdict == xmcr_pkg::VERDICT_ACCEPTED || verdict == xmcr_pkg::VERDICT_DUPLICATE ||
        verdict == xmcr_pkg::VERDICT_DONE)) &&
      (reply_byte == xmcr_pkg::ACK || reply_byte == xmcr_pkg::NAK))
    else $error("reply byte does not match verdict");

  // unused fields read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (data_valid || (data_byte == 8'd0 && byte_index == '0)) &&
                  (reply_valid || reply_byte == 8'd0))
    else $error("idle field not zero");

endmodule

bind xmodem_checksum_receiver_core xmcr_checker u_xmcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .data_valid  (out_o.data_valid),
  .data_byte   (out_o.data_byte),
  .byte_index  (out_o.byte_index),
  .reply_valid (out_o.reply_valid),
  .reply_byte  (out_o.reply_byte),
  .verdict     (out_o.verdict)
);

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for the checksum xmodem receiver core
// predicts each result transaction in a scoreboard class, drives in_i and apb by tasks and out_o.ready by a process
// depends on xmcr_pkg, xmcr_if and xmodem_checksum_receiver_core
`default_nettype none

module tb;
  import xmcr_pkg::*;

  localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 130;
  localparam int NUM_SETTINGS = 6;

  typedef enum logic [2:0] {
    RX_STOPPED, RX_HUNT, RX_NUMBER, RX_COMPLEMENT, RX_DATA, RX_CHECKSUM, RX_PURGE
  } rx_phase_e;

  class checksum_board;
    logic [15:0] short_to;
    logic [15:0] long_to;
    logic [7:0]  err_limit;
    rx_phase_e   phase;
    logic [7:0]  last_blk;
    logic [7:0]  hdr_blk;
    int          count;
    logic [7:0]  sum;
    logic [7:0]  err_run;
    logic [15:0] err_total;
    logic [15:0] silence;
    bit          dup_purge;
    res_t        pending[$];
    int          mismatches;

    function new();
      short_to   = SHORT_TIMEOUT_RST;
      long_to    = LONG_TIMEOUT_RST;
      err_limit  = ERROR_LIMIT_RST;
      phase      = RX_STOPPED;
      last_blk   = '0;
      hdr_blk    = '0;
      count      = 0;
      sum        = '0;
      err_run    = '0;
      err_total  = '0;
      silence    = '0;
      dup_purge  = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_SHORT_TIMEOUT: short_to = value[15:0];
        REG_LONG_TIMEOUT:  long_to = value[15:0];
        REG_ERROR_LIMIT:   err_limit = value[7:0];
        default: ;
      endcase
    endfunction

    function void bump_errors();
      if (err_run != 8'hFF) err_run++;
      if (last_blk != 8'd0 && err_total != 16'hFFFF) err_total++;
    endfunction

    function logic [VERDICT_W-1:0] fail_verdict();
      if (err_run >= err_limit) begin
        phase = RX_STOPPED;
        return VERDICT_ABORTED;
      end
      phase = RX_HUNT;
      return VERDICT_ERROR;
    endfunction

    function void start_purge(bit dup);
      dup_purge = dup;
      silence = '0;
      phase = RX_PURGE;
    endfunction

    // a zero limit behaves as one tick
    function bit quiet_expired(logic [15:0] lim);
      if (silence != 16'hFFFF) silence++;
      return silence >= ((lim == 16'd0) ? 16'd1 : lim);
    endfunction

    function void note_accepted(logic [ACTION_W-1:0] act, logic [7:0] b);
      res_t r;
      logic [8:0] pair;
      r = '0;
      if (act == ACT_START) begin
        last_blk = '0;
        hdr_blk = '0;
        count = 0;
        sum = '0;
        err_run = '0;
        err_total = '0;
        silence = '0;
        dup_purge = 1'b0;
        phase = RX_HUNT;
        return;
      end
      if ((act != ACT_BYTE && act != ACT_TICK) || phase == RX_STOPPED) return;

      if (act == ACT_BYTE) begin
        silence = '0;
        case (phase)
          RX_HUNT: begin
            if (b == SOH) begin
              phase = RX_NUMBER;
            end else if (b == EOT) begin
              r.reply_valid = 1'b1;
              r.reply_byte = ACK;
              r.verdict = VERDICT_DONE;
              phase = RX_STOPPED;
            end
          end
          RX_NUMBER: begin
            hdr_blk = b;
            phase = RX_COMPLEMENT;
          end
          RX_COMPLEMENT: begin
            pair = {1'b0, hdr_blk} + {1'b0, b};
            if (pair != 9'd255) begin
              bump_errors();
              start_purge(1'b0);
            end else if (hdr_blk == last_blk + 8'd1) begin
              count = 0;
              sum = '0;
              phase = RX_DATA;
            end else if (hdr_blk == last_blk) begin
              start_purge(1'b1);
            end else begin
              bump_errors();
              start_purge(1'b0);
            end
          end
          RX_DATA: begin
            r.data_valid = 1'b1;
            r.data_byte = b;
            r.byte_index = count[INDEX_W-1:0];
            sum += b;
            count++;
            if (count >= BLOCK_BYTES) phase = RX_CHECKSUM;
          end
          RX_CHECKSUM: begin
            if (b == sum) begin
              err_run = '0;
              last_blk = hdr_blk;
              r.reply_valid = 1'b1;
              r.reply_byte = ACK;
              r.verdict = VERDICT_ACCEPTED;
              phase = RX_HUNT;
            end else begin
              bump_errors();
              start_purge(1'b0);
            end
          end
          default: ;
        endcase
      end else if (phase == RX_HUNT) begin
        if (quiet_expired(long_to)) begin
          bump_errors();
          start_purge(1'b0);
        end
      end else if (phase == RX_PURGE) begin
        if (quiet_expired(short_to)) begin
          silence = '0;
          r.reply_valid = 1'b1;
          if (dup_purge) begin
            r.reply_byte = ACK;
            r.verdict = VERDICT_DUPLICATE;
            phase = RX_HUNT;
          end else begin
            r.reply_byte = NAK;
            r.verdict = fail_verdict();
          end
          dup_purge = 1'b0;
        end
      end else if (quiet_expired(short_to)) begin
        // line went quiet inside a packet
        silence = '0;
        bump_errors();
        r.reply_valid = 1'b1;
        r.reply_byte = NAK;
        r.verdict = fail_verdict();
      end

      if (r.data_valid || r.reply_valid || r.verdict != VERDICT_NONE) begin
        r.block_number = last_blk;
        r.retry_errors = err_run;
        r.total_errors = err_total;
        pending.push_back(r);
      end
    endfunction

    function string fmt(res_t r);
      return $sformatf("dv=%0b db=%02h idx=%0d rv=%0b rb=%02h vd=%0d blk=%0d re=%0d te=%0d",
                       r.data_valid, r.data_byte, r.byte_index, r.reply_valid, r.reply_byte,
                       r.verdict, r.block_number, r.retry_errors, r.total_errors);
    endfunction

    function void flag(string what, res_t want, res_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch (%s) at %0t", what, $realtime);
        $display("  expected %s", fmt(want));
        $display("  actual   %s", fmt(got));
      end
    endfunction

    function void check_result(res_t got);
      res_t  want;
      string bad;
      if (pending.size() == 0) begin
        flag("no transaction expected", '0, got);
        return;
      end
      want = pending.pop_front();
      bad = "";
      if (got.data_valid !== want.data_valid) bad = {bad, " data_valid"};
      if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
      if (got.byte_index !== want.byte_index) bad = {bad, " byte_index"};
      if (got.reply_valid !== want.reply_valid) bad = {bad, " reply_valid"};
      if (got.reply_byte !== want.reply_byte) bad = {bad, " reply_byte"};
      if (got.verdict !== want.verdict) bad = {bad, " verdict"};
      if (got.block_number !== want.block_number) bad = {bad, " block_number"};
      if (got.retry_errors !== want.retry_errors) bad = {bad, " retry_errors"};
      if (got.total_errors !== want.total_errors) bad = {bad, " total_errors"};
      if (bad != "") flag({"field", bad}, want, got);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  xmcr_in_if  in_if();
  xmcr_out_if out_if();

  checksum_board sb;
  bit            calm;
  int            items_done;
  int            stall_left;
  int            quiet_run;

  xmodem_checksum_receiver_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random stall bursts unless calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t seen;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      seen.data_valid   = out_if.data_valid;
      seen.data_byte    = out_if.data_byte;
      seen.byte_index   = out_if.byte_index;
      seen.reply_valid  = out_if.reply_valid;
      seen.reply_byte   = out_if.reply_byte;
      seen.verdict      = out_if.verdict;
      seen.block_number = out_if.block_number;
      seen.retry_errors = out_if.retry_errors;
      seen.total_errors = out_if.total_errors;
      sb.check_result(seen);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) || psel) begin
      quiet_run = 0;
    end else begin
      quiet_run++;
    end
    if (quiet_run >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic logic [7:0] rand_nonzero();
    logic [31:0] r;
    r = $urandom_range(1, 255);
    return r[7:0];
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    if (act == ACT_START || ((act == ACT_BYTE || act == ACT_TICK) && sb.phase != RX_STOPPED))
      items_done++;
    sb.note_accepted(act, b);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // a tick may still be in flight with no result
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // upper pwdata bits are random, only the register width counts
  task automatic configure(input logic [15:0] short_ticks, input logic [15:0] long_ticks,
                           input logic [7:0] limit);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_SHORT_TIMEOUT, {junk[31:16], short_ticks});
    junk = $urandom;
    write_reg(REG_LONG_TIMEOUT, {junk[31:16], long_ticks});
    junk = $urandom;
    write_reg(REG_ERROR_LIMIT, {junk[31:8], limit});
  endtask

  task automatic send_frame(input logic [7:0] num, input logic [7:0] comp, input int n_data,
                            input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int i;
    sum = '0;
    send_item(ACT_BYTE, SOH);
    send_item(ACT_BYTE, num);
    send_item(ACT_BYTE, comp);
    for (i = 0; i < n_data; i++) begin
      b = rand_byte();
      sum += b;
      send_item(ACT_BYTE, b);
    end
    if (n_data == BLOCK_BYTES) begin
      if (!good_sum) sum += rand_nonzero();
      send_item(ACT_BYTE, sum);
    end
  endtask

  // ticks up to the timeout when it is short enough, else a few
  task automatic quiet_line(input logic [15:0] lim);
    int eff;
    int n;
    int i;
    eff = (lim == 16'd0) ? 1 : int'(lim);
    if (eff <= 40) n = eff + $urandom_range(0, 1);
    else n = $urandom_range(1, 20);
    for (i = 0; i < n; i++) send_item(ACT_TICK, rand_byte());
  endtask

  task automatic random_traffic(input int budget);
    int first;
    int pick;
    int n;
    int i;
    logic [7:0] nxt;
    logic [7:0] off;
    first = items_done;
    while (items_done - first < budget) begin
      pick = $urandom_range(0, 99);
      nxt = sb.last_blk + 8'd1;
      if (sb.phase == RX_STOPPED && pick < 85) begin
        send_item(ACT_START, rand_byte());
      end else if (pick < 50) begin
        send_frame(nxt, ~nxt, BLOCK_BYTES, 1'b1);
      end else if (pick < 58) begin
        send_frame(sb.last_blk, ~sb.last_blk, $urandom_range(0, BLOCK_BYTES), 1'b1);
        quiet_line(sb.short_to);
      end else if (pick < 68) begin
        case ($urandom_range(0, 3))
          0: send_frame(nxt, ~nxt ^ rand_nonzero(), $urandom_range(0, 8), 1'b1);
          1: send_frame(nxt, ~nxt, BLOCK_BYTES, 1'b0);
          2: begin
            // neither the next nor the last block
            off = 8'($urandom_range(1, 254));
            send_frame(nxt + off, ~(nxt + off), $urandom_range(0, 8), 1'b1);
          end
          default: send_frame(nxt, ~nxt, $urandom_range(0, BLOCK_BYTES - 1), 1'b1);
        endcase
        quiet_line(sb.short_to);
      end else if (pick < 80) begin
        quiet_line(sb.long_to);
      end else if (pick < 90) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) send_item(ACT_BYTE, rand_byte());
      end else if (pick < 94) begin
        send_item(ACT_BYTE, EOT);
      end else if (pick < 97) begin
        send_item(ACT_START, rand_byte());
      end else begin
        send_item(ACT_UNUSED, rand_byte());
      end
    end
  endtask

  initial begin
    logic [15:0] short_set [NUM_SETTINGS];
    logic [15:0] long_set [NUM_SETTINGS];
    logic [7:0]  limit_set [NUM_SETTINGS];
    int k;
    short_set = '{16'd3, 16'd1, 16'd0, 16'd65535, 16'd1000, 16'd2};
    long_set  = '{16'd4, 16'd1, 16'd0, 16'd65535, 16'd10000, 16'd5};
    limit_set = '{8'd4, 8'd1, 8'd0, 8'd255, 8'd10, 8'd3};

    sb = new();
    in_if.valid   = 1'b0;
    in_if.action  = ACT_BYTE;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    items_done    = 0;
    stall_left    = 0;
    quiet_run     = 0;
    rst_n         = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(16'd2, 16'd1, 8'd3);
    // stopped receiver ignores bytes, ticks and the unused action
    send_item(ACT_BYTE, SOH);
    send_item(ACT_TICK, 8'hFF);
    send_item(ACT_UNUSED, 8'hFF);
    send_item(ACT_START, 8'h00);
    // noise while hunting, then a header timeout and its nak
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    // repeat of block 0 is acked after silence
    send_item(ACT_BYTE, SOH);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    // bad complement, byte dropped during purge
    send_item(ACT_BYTE, SOH);
    send_item(ACT_BYTE, 8'h05);
    send_item(ACT_BYTE, 8'h05);
    send_item(ACT_BYTE, EOT);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    // silence inside a packet reaches the error limit
    send_item(ACT_BYTE, SOH);
    send_item(ACT_BYTE, 8'h01);
    send_item(ACT_BYTE, 8'hFE);
    send_item(ACT_BYTE, 8'hAA);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_START, 8'hFF);
    send_item(ACT_BYTE, EOT);

    for (k = 0; k < NUM_SETTINGS; k++) begin
      drain_results();
      if (k == NUM_SETTINGS - 1) calm = 1'b1;
      configure(short_set[k], long_set[k], limit_set[k]);
      random_traffic(PHASE_ITEMS);
    end
    drain_results();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/xmcr_pkg.sv
hw/rtl/xmcr_if.sv
hw/rtl/xmcr_cfg_regs.sv
hw/rtl/xmcr_engine.sv
hw/rtl/xmcr_out_reg.sv
hw/rtl/xmodem_checksum_receiver_core.sv
hw/rtl/xmcr_checker.sv
tb/tb.sv
